// ----- rtl/core/stack_machine_data_unit_defines.svh -----
// ----------------------------------------------------------------------------
// stack machine data unit assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_DATA_UNIT_DEFINES_SVH
`define STACK_MACHINE_DATA_UNIT_DEFINES_SVH

// same-cycle implication
`define SMDU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error("smdu check failed");

// next-cycle implication
`define SMDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("smdu check failed");

`endif

// ----- rtl/core/smdu_pkg.sv -----
// ----------------------------------------------------------------------------
// smdu_pkg
// opcodes, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package smdu_pkg;

    localparam logic [4:0] OP_PUSH = 5'd0;
    localparam logic [4:0] OP_DUP  = 5'd1;
    localparam logic [4:0] OP_DROP = 5'd2;
    localparam logic [4:0] OP_SWAP = 5'd3;
    localparam logic [4:0] OP_ROT  = 5'd4;
    localparam logic [4:0] OP_PICK = 5'd5;
    localparam logic [4:0] OP_ADD  = 5'd6;
    localparam logic [4:0] OP_SUB  = 5'd7;
    localparam logic [4:0] OP_MUL  = 5'd8;
    localparam logic [4:0] OP_DIV  = 5'd9;
    localparam logic [4:0] OP_NEG  = 5'd10;
    localparam logic [4:0] OP_AND  = 5'd11;
    localparam logic [4:0] OP_OR   = 5'd12;
    localparam logic [4:0] OP_NOT  = 5'd13;
    localparam logic [4:0] OP_GT   = 5'd14;
    localparam logic [4:0] OP_EQ   = 5'd15;
    localparam logic [4:0] OP_POP  = 5'd16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_PICKNEG = 3'd2;
    localparam logic [2:0] ST_OVER    = 3'd3;
    localparam logic [2:0] ST_DIVZERO = 3'd4;

    localparam logic [31:0] ALL_ONES = ~32'd0;
    localparam logic [31:0] LOW_MASK = 32'h0000_ffff;

    // stack address selects
    typedef enum logic [2:0] {
        ADR_D, ADR_D1, ADR_D2, ADR_D3, ADR_PICK
    } adr_t;

    // data sources for stack writes and the result value
    typedef enum logic [2:0] {
        SRC_PV, SRC_OP0, SRC_OP1, SRC_OP2, SRC_ALU, SRC_Q, SRC_ZERO
    } src_t;

    typedef enum logic [1:0] {
        DEP_KEEP, DEP_INC, DEP_DEC
    } dep_t;

    typedef struct packed {
        logic       in_ld;
        logic       rd_en;
        adr_t       rd_adr;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       wr_en;
        adr_t       wr_adr;
        src_t       wr_src;
        logic       val_ld;
        src_t       val_src;
        dep_t       dep;
        logic       div_start;
        logic       out_ld;
        logic [2:0] status;
    } cmd_t;

    typedef struct packed {
        logic [4:0] op;
        logic       under;
        logic       over;
        logic       pick_neg;
        logic       pick_far;
        logic       div_zero;
        logic       dep_zero;
        logic       div_busy;
        logic       out_free;
    } stat_t;

    // operands an opcode needs on the stack
    function automatic logic [1:0] op_need(input logic [4:0] op);
        logic [1:0] n;
        n = 2'd0;
        if (op == OP_DUP || op == OP_DROP || op == OP_PICK || op == OP_NEG ||
            op == OP_NOT || op == OP_POP)
            n = 2'd1;
        else if (op == OP_SWAP || (op >= OP_ADD && op <= OP_EQ))
            n = 2'd2;
        else if (op == OP_ROT)
            n = 2'd3;
        return n;
    endfunction

endpackage

// ----- rtl/core/stack_machine_data_unit.sv -----
// ----------------------------------------------------------------------------
// stack_machine_data_unit
// data stack and alu of a stack-language machine, one request in, one out
// ----------------------------------------------------------------------------
// One request at a time. Each request reads its operands from the stack ram
// one entry at a time (address, then registered read data), then writes
// results back one entry per cycle, so the ram port sets the pace. A push
// writes and goes straight to the hand-off; drop, underflow, overflow and
// unused opcodes only fetch the new top (none when the stack ends up empty),
// and a bad pick index skips the pick read. Divide runs a one-bit-per-cycle
// divider, which is skipped on divide by zero. The sequencer holds a
// finished result while the output register is still occupied, then returns
// to idle, where the next request can be accepted. A finished result sits in
// the output register while the next request is accepted. The sixteen-bit
// mode write is only taken while the sequencer is idle. No clearing pass is
// needed after reset: only entries below the depth are ever read.
`include "stack_machine_data_unit_defines.svh"

module stack_machine_data_unit #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         opcode,
    input  logic signed [31:0] push_value,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] value,
    output logic [8:0]         depth,
    // configuration: sixteen-bit mode
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    smdu_pkg::cmd_t  cmd;
    smdu_pkg::stat_t st;
    logic [31:0]     value_raw;

    // register write taken only while no request is in flight
    assign cfg_ready = in_ready;

    // sequencer
    smdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // stack storage and arithmetic
    smdu_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .opcode     (opcode),
        .push_value ($unsigned(push_value)),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_status (status),
        .out_value  (value_raw),
        .out_depth  (depth)
    );

    assign value = $signed(value_raw);

    // one request in flight: no second acceptance straight after one
    `SMDU_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // status codes stay within the defined set
    `SMDU_ASSERT_NOW(a_status_range, out_valid, status <= smdu_pkg::ST_DIVZERO)
    // overflow is only reported on a full stack
    `SMDU_ASSERT_NOW(a_over_full, out_valid && status == smdu_pkg::ST_OVER,
                     depth == 9'(STACK_DEPTH))

endmodule

// ----- rtl/core/smdu_ram.sv -----
// ----------------------------------------------------------------------------
// smdu_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module smdu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/smdu_div.sv -----
// ----------------------------------------------------------------------------
// smdu_div
// signed 32-bit divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
module smdu_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [32:0] trial;

    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 32'd0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dvs_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

// ----- rtl/core/smdu_ctrl.sv -----
// ----------------------------------------------------------------------------
// smdu_ctrl
// sequencer: operand reads, writes back, divider wait and result hand-off
// ----------------------------------------------------------------------------
module smdu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smdu_pkg::stat_t st,
    output smdu_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ, S_CAP, S_EXEC, S_W2, S_W3,
        S_PCAP, S_DIV, S_TOP, S_TCAP, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic [2:0] status_reg, status_next;
    logic [1:0] need;

    assign need     = smdu_pkg::op_need(st.op);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.rd_adr  = smdu_pkg::ADR_D1;
        cmd.wr_adr  = smdu_pkg::ADR_D;
        cmd.wr_src  = smdu_pkg::SRC_ALU;
        cmd.val_src = smdu_pkg::SRC_ALU;
        cmd.dep     = smdu_pkg::DEP_KEEP;
        cmd.status  = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_ld   = 1'b1;
                    status_next = smdu_pkg::ST_OK;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                k_next = 2'd0;
                priority if (st.op > smdu_pkg::OP_POP)
                begin
                    state_next = S_TOP;
                end
                else if (st.under)
                begin
                    status_next = smdu_pkg::ST_UNDER;
                    state_next  = S_TOP;
                end
                else if ((st.op == smdu_pkg::OP_PUSH || st.op == smdu_pkg::OP_DUP) &&
                         st.over)
                begin
                    status_next = smdu_pkg::ST_OVER;
                    state_next  = S_TOP;
                end
                else if (st.op == smdu_pkg::OP_PUSH)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_adr  = smdu_pkg::ADR_D;
                    cmd.wr_src  = smdu_pkg::SRC_PV;
                    cmd.val_ld  = 1'b1;
                    cmd.val_src = smdu_pkg::SRC_PV;
                    cmd.dep     = smdu_pkg::DEP_INC;
                    state_next  = S_DONE;
                end
                else if (st.op == smdu_pkg::OP_DROP)
                begin
                    cmd.dep    = smdu_pkg::DEP_DEC;
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                unique case (k_reg)
                    2'd0:    cmd.rd_adr = smdu_pkg::ADR_D1;
                    2'd1:    cmd.rd_adr = smdu_pkg::ADR_D2;
                    default: cmd.rd_adr = smdu_pkg::ADR_D3;
                endcase
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_idx = k_reg;
                if (k_reg + 2'd1 < need)
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                cmd.val_ld = 1'b1;
                priority if (st.op == smdu_pkg::OP_DUP)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_adr  = smdu_pkg::ADR_D;
                    cmd.wr_src  = smdu_pkg::SRC_OP0;
                    cmd.val_src = smdu_pkg::SRC_OP0;
                    cmd.dep     = smdu_pkg::DEP_INC;
                end
                else if (st.op == smdu_pkg::OP_SWAP)
                begin
                    cmd.val_ld = 1'b0;
                    cmd.wr_en  = 1'b1;
                    cmd.wr_adr = smdu_pkg::ADR_D1;
                    cmd.wr_src = smdu_pkg::SRC_OP1;
                    state_next = S_W2;
                end
                else if (st.op == smdu_pkg::OP_ROT)
                begin
                    cmd.val_ld = 1'b0;
                    cmd.wr_en  = 1'b1;
                    cmd.wr_adr = smdu_pkg::ADR_D3;
                    cmd.wr_src = smdu_pkg::SRC_OP1;
                    state_next = S_W2;
                end
                else if (st.op == smdu_pkg::OP_PICK)
                begin
                    cmd.val_src = smdu_pkg::SRC_OP0;
                    if (st.pick_neg)
                    begin
                        status_next = smdu_pkg::ST_PICKNEG;
                    end
                    else if (st.pick_far)
                    begin
                        status_next = smdu_pkg::ST_UNDER;
                    end
                    else
                    begin
                        cmd.val_ld = 1'b0;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_adr = smdu_pkg::ADR_PICK;
                        state_next = S_PCAP;
                    end
                end
                else if (st.op == smdu_pkg::OP_NEG || st.op == smdu_pkg::OP_NOT)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_adr  = smdu_pkg::ADR_D1;
                    cmd.wr_src  = smdu_pkg::SRC_ALU;
                    cmd.val_src = smdu_pkg::SRC_ALU;
                end
                else if (st.op == smdu_pkg::OP_POP)
                begin
                    cmd.val_src = smdu_pkg::SRC_OP0;
                    cmd.dep     = smdu_pkg::DEP_DEC;
                end
                else if (st.op == smdu_pkg::OP_DIV)
                begin
                    cmd.val_src = smdu_pkg::SRC_OP0;
                    if (st.div_zero)
                    begin
                        status_next = smdu_pkg::ST_DIVZERO;
                    end
                    else
                    begin
                        cmd.val_ld    = 1'b0;
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_adr  = smdu_pkg::ADR_D2;
                    cmd.wr_src  = smdu_pkg::SRC_ALU;
                    cmd.val_src = smdu_pkg::SRC_ALU;
                    cmd.dep     = smdu_pkg::DEP_DEC;
                end
            end
            S_W2:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_adr = smdu_pkg::ADR_D2;
                cmd.wr_src = smdu_pkg::SRC_OP0;
                if (st.op == smdu_pkg::OP_ROT)
                begin
                    state_next = S_W3;
                end
                else
                begin
                    cmd.val_ld  = 1'b1;
                    cmd.val_src = smdu_pkg::SRC_OP1;
                    state_next  = S_DONE;
                end
            end
            S_W3:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_adr  = smdu_pkg::ADR_D1;
                cmd.wr_src  = smdu_pkg::SRC_OP2;
                cmd.val_ld  = 1'b1;
                cmd.val_src = smdu_pkg::SRC_OP2;
                state_next  = S_DONE;
            end
            S_PCAP:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_adr  = smdu_pkg::ADR_D1;
                cmd.wr_src  = smdu_pkg::SRC_Q;
                cmd.val_ld  = 1'b1;
                cmd.val_src = smdu_pkg::SRC_Q;
                state_next  = S_DONE;
            end
            S_DIV:
            begin
                if (!st.div_busy)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_adr  = smdu_pkg::ADR_D2;
                    cmd.wr_src  = smdu_pkg::SRC_ALU;
                    cmd.val_ld  = 1'b1;
                    cmd.val_src = smdu_pkg::SRC_ALU;
                    cmd.dep     = smdu_pkg::DEP_DEC;
                    state_next  = S_DONE;
                end
            end
            S_TOP:
            begin
                if (st.dep_zero)
                begin
                    cmd.val_ld  = 1'b1;
                    cmd.val_src = smdu_pkg::SRC_ZERO;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_adr = smdu_pkg::ADR_D1;
                    state_next = S_TCAP;
                end
            end
            S_TCAP:
            begin
                cmd.val_ld  = 1'b1;
                cmd.val_src = smdu_pkg::SRC_Q;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= 2'd0;
            status_reg <= smdu_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- rtl/core/smdu_dpath.sv -----
// ----------------------------------------------------------------------------
// smdu_dpath
// stack memory, depth, operand registers, alu, divider and result register
// ----------------------------------------------------------------------------
module smdu_dpath #(
    parameter int STACK_DEPTH = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  smdu_pkg::cmd_t  cmd,
    output smdu_pkg::stat_t st,
    input  logic [4:0]      opcode,
    input  logic [31:0]     push_value,
    input  logic            cfg_we,
    input  logic            cfg_data,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [2:0]      out_status,
    output logic [31:0]     out_value,
    output logic [8:0]      out_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [4:0]    op_reg;
    logic [31:0]   pv_reg;
    logic [DW-1:0] depth_reg, depth_next;
    logic          mode_reg;
    logic [31:0]   opnd_reg [3];
    logic [31:0]   val_reg;
    logic          out_valid_reg;
    logic [2:0]    out_status_reg;
    logic [31:0]   out_value_reg;
    logic [8:0]    out_depth_reg;

    logic [DW-1:0] depth_m1, depth_m2, depth_m3, pick_pos;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   rd_data, wr_data, val_data;
    logic [31:0]   alu_a, alu_b, alu_raw, alu_res, div_q;
    logic          div_busy;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign depth_m3 = depth_reg - DW'(3);
    // only used when the index lies below depth - 1
    assign pick_pos = depth_m2 - opnd_reg[0][DW-1:0];

    function automatic logic [AW-1:0] adr_mux(
        input smdu_pkg::adr_t sel,
        input logic [DW-1:0]  d0,
        input logic [DW-1:0]  d1,
        input logic [DW-1:0]  d2,
        input logic [DW-1:0]  d3,
        input logic [DW-1:0]  dp
    );
        logic [DW-1:0] a;
        unique case (sel)
            smdu_pkg::ADR_D:    a = d0;
            smdu_pkg::ADR_D1:   a = d1;
            smdu_pkg::ADR_D2:   a = d2;
            smdu_pkg::ADR_D3:   a = d3;
            smdu_pkg::ADR_PICK: a = dp;
            default:            a = d1;
        endcase
        return a[AW-1:0];
    endfunction

    assign rd_addr = adr_mux(cmd.rd_adr, depth_reg, depth_m1, depth_m2, depth_m3, pick_pos);
    assign wr_addr = adr_mux(cmd.wr_adr, depth_reg, depth_m1, depth_m2, depth_m3, pick_pos);

    function automatic logic [31:0] src_mux(
        input smdu_pkg::src_t sel,
        input logic [31:0]    pv,
        input logic [31:0]    o0,
        input logic [31:0]    o1,
        input logic [31:0]    o2,
        input logic [31:0]    alu,
        input logic [31:0]    q
    );
        logic [31:0] r;
        unique case (sel)
            smdu_pkg::SRC_PV:   r = pv;
            smdu_pkg::SRC_OP0:  r = o0;
            smdu_pkg::SRC_OP1:  r = o1;
            smdu_pkg::SRC_OP2:  r = o2;
            smdu_pkg::SRC_ALU:  r = alu;
            smdu_pkg::SRC_Q:    r = q;
            default:            r = 32'd0;
        endcase
        return r;
    endfunction

    assign wr_data  = src_mux(cmd.wr_src, pv_reg, opnd_reg[0], opnd_reg[1], opnd_reg[2],
                              alu_res, rd_data);
    assign val_data = src_mux(cmd.val_src, pv_reg, opnd_reg[0], opnd_reg[1], opnd_reg[2],
                              alu_res, rd_data);

    // a is the entry under the top, b the top
    assign alu_a = opnd_reg[1];
    assign alu_b = opnd_reg[0];

    always_comb
    begin
        unique case (op_reg)
            smdu_pkg::OP_ADD: alu_raw = alu_a + alu_b;
            smdu_pkg::OP_SUB: alu_raw = alu_a - alu_b;
            smdu_pkg::OP_MUL: alu_raw = alu_a * alu_b;
            smdu_pkg::OP_DIV: alu_raw = div_q;
            smdu_pkg::OP_NEG: alu_raw = 32'd0 - alu_b;
            smdu_pkg::OP_NOT: alu_raw = ~alu_b;
            smdu_pkg::OP_GT:
                alu_raw = ($signed(alu_a) > $signed(alu_b)) ? smdu_pkg::ALL_ONES : 32'd0;
            smdu_pkg::OP_EQ:
                alu_raw = (alu_a == alu_b) ? smdu_pkg::ALL_ONES : 32'd0;
            smdu_pkg::OP_AND: alu_raw = alu_a & alu_b;
            smdu_pkg::OP_OR:  alu_raw = alu_a | alu_b;
            default:          alu_raw = 32'd0;
        endcase
    end

    // bitwise and/or stay full width
    assign alu_res = (mode_reg && op_reg != smdu_pkg::OP_AND && op_reg != smdu_pkg::OP_OR)
                     ? (alu_raw & smdu_pkg::LOW_MASK) : alu_raw;

    smdu_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    smdu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (alu_a),
        .divisor  (alu_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        unique case (cmd.dep)
            smdu_pkg::DEP_INC: depth_next = depth_reg + DW'(1);
            smdu_pkg::DEP_DEC: depth_next = depth_m1;
            default:           depth_next = depth_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_ld)
        begin
            op_reg <= opcode;
            pv_reg <= push_value;
        end
        if (cmd.cap_en)
        begin
            opnd_reg[cmd.cap_idx] <= rd_data;
        end
        if (cmd.val_ld)
        begin
            val_reg <= val_data;
        end
        if (cmd.out_ld)
        begin
            out_status_reg <= cmd.status;
            out_value_reg  <= val_reg;
            out_depth_reg  <= 9'(depth_reg);
        end
    end

    assign st.op       = op_reg;
    assign st.under    = (op_reg <= smdu_pkg::OP_POP) &&
                         (depth_reg < DW'(smdu_pkg::op_need(op_reg)));
    assign st.over     = (depth_reg == DW'(STACK_DEPTH));
    assign st.pick_neg = opnd_reg[0][31];
    assign st.pick_far = (32'(depth_m1) <= opnd_reg[0]);
    assign st.div_zero = (opnd_reg[0] == 32'd0);
    assign st.dep_zero = (depth_reg == '0);
    assign st.div_busy = div_busy;
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_depth  = out_depth_reg;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack machine data unit testbench
// drives opcode requests, predicts each result against a private stack copy
// and checks status, value and depth of every result in order
// ----------------------------------------------------------------------------
module testbench;

    localparam int          STACK_SIZE   = 256;
    localparam logic [4:0]  OP_SPARE_LO  = 5'd17;   // first opcode with no function
    localparam logic [4:0]  OP_SPARE_HI  = 5'd31;
    localparam int          STALL_LIMIT  = 4000;    // cycles with no handshake at all
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] val;
        logic [8:0]  dep;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [4:0]         opcode;
    logic signed [31:0] push_value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [8:0]         depth;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // private copy of the stack and the mode register
    logic [31:0] model_stack [STACK_SIZE];
    int unsigned model_depth;
    logic        model_half;

    result_t     expected_results[$];
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    stack_machine_data_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value      (value),
        .depth      (depth),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // mask arithmetic results in sixteen-bit mode
    function automatic logic [31:0] fit16(input logic [31:0] v);
        return model_half ? (v & smdu_pkg::LOW_MASK) : v;
    endfunction

    // signed division truncating toward zero, min / -1 wraps
    function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // apply one opcode to the private stack and work out its result
    task automatic apply_stack_op(input logic [4:0] op, input logic [31:0] pv,
                                  output result_t r);
        int unsigned d;
        int unsigned need;
        logic [2:0]  st;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] n;
        logic [31:0] res;
        logic [31:0] popped_val;
        bit          popped;
        d      = model_depth;
        st     = smdu_pkg::ST_OK;
        popped = 1'b0;
        popped_val = '0;
        res    = '0;
        case (op)
            smdu_pkg::OP_DUP, smdu_pkg::OP_DROP, smdu_pkg::OP_PICK, smdu_pkg::OP_NEG,
            smdu_pkg::OP_NOT, smdu_pkg::OP_POP:
                need = 1;
            smdu_pkg::OP_SWAP, smdu_pkg::OP_ADD, smdu_pkg::OP_SUB, smdu_pkg::OP_MUL,
            smdu_pkg::OP_DIV, smdu_pkg::OP_AND, smdu_pkg::OP_OR, smdu_pkg::OP_GT,
            smdu_pkg::OP_EQ:
                need = 2;
            smdu_pkg::OP_ROT:
                need = 3;
            default:
                need = 0;
        endcase
        if (d < need)
            st = smdu_pkg::ST_UNDER;
        else
        begin
            case (op)
                smdu_pkg::OP_PUSH, smdu_pkg::OP_DUP:
                begin
                    if (d >= STACK_SIZE)
                        st = smdu_pkg::ST_OVER;
                    else
                    begin
                        model_stack[d] = (op == smdu_pkg::OP_PUSH) ? pv : model_stack[d-1];
                        model_depth = d + 1;
                    end
                end
                smdu_pkg::OP_DROP: model_depth = d - 1;
                smdu_pkg::OP_SWAP:
                begin
                    a = model_stack[d-1];
                    model_stack[d-1] = model_stack[d-2];
                    model_stack[d-2] = a;
                end
                smdu_pkg::OP_ROT:
                begin
                    a = model_stack[d-3];
                    model_stack[d-3] = model_stack[d-2];
                    model_stack[d-2] = model_stack[d-1];
                    model_stack[d-1] = a;
                end
                smdu_pkg::OP_PICK:
                begin
                    n = model_stack[d-1];
                    if (n[31])
                        st = smdu_pkg::ST_PICKNEG;
                    else if (n >= d - 1)
                        st = smdu_pkg::ST_UNDER;
                    else
                        model_stack[d-1] = model_stack[d-2-n];
                end
                smdu_pkg::OP_NEG: model_stack[d-1] = fit16(-model_stack[d-1]);
                smdu_pkg::OP_NOT: model_stack[d-1] = fit16(~model_stack[d-1]);
                smdu_pkg::OP_POP:
                begin
                    popped_val  = model_stack[d-1];
                    popped      = 1'b1;
                    model_depth = d - 1;
                end
                smdu_pkg::OP_ADD, smdu_pkg::OP_SUB, smdu_pkg::OP_MUL, smdu_pkg::OP_DIV,
                smdu_pkg::OP_AND, smdu_pkg::OP_OR, smdu_pkg::OP_GT, smdu_pkg::OP_EQ:
                begin
                    a = model_stack[d-2];
                    b = model_stack[d-1];
                    if (op == smdu_pkg::OP_DIV && b == 0)
                        st = smdu_pkg::ST_DIVZERO;
                    else
                    begin
                        case (op)
                            smdu_pkg::OP_ADD: res = fit16(a + b);
                            smdu_pkg::OP_SUB: res = fit16(a - b);
                            smdu_pkg::OP_MUL: res = fit16(a * b);
                            smdu_pkg::OP_DIV: res = fit16(quot_trunc(a, b));
                            smdu_pkg::OP_AND: res = a & b;
                            smdu_pkg::OP_OR:  res = a | b;
                            smdu_pkg::OP_GT:
                                res = ($signed(a) > $signed(b)) ?
                                      fit16(smdu_pkg::ALL_ONES) : '0;
                            default:
                                res = (a == b) ? fit16(smdu_pkg::ALL_ONES) : '0;
                        endcase
                        model_stack[d-2] = res;
                        model_depth = d - 1;
                    end
                end
                default: ;
            endcase
        end
        r.st  = st;
        r.val = popped ? popped_val : (model_depth != 0 ? model_stack[model_depth-1] : '0);
        r.dep = model_depth[8:0];
    endtask

    // send one request, record its prediction on acceptance, then maybe idle
    task automatic send_op(input logic [4:0] op, input logic [31:0] pv);
        result_t r;
        int      gap;
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= pv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_stack_op(op, pv, r);
        expected_results = {expected_results, r};
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lower valid and wait until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write sixteen-bit mode while idle
    task automatic set_mode(input logic m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        model_half = m;
    endtask

    // operand value: small, extreme or fully random
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 4);
            1:       return -$urandom_range(1, 3);
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3:       return $urandom_range(0, 16'hffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        set_mode(1'b0);
        // underflow on an empty stack, then an unused opcode
        send_op(smdu_pkg::OP_POP, '0);
        send_op(smdu_pkg::OP_ADD, '0);
        send_op(smdu_pkg::OP_ROT, '0);
        send_op(OP_SPARE_HI, 32'hffff_ffff);
        // field extremes and signed division wrap
        send_op(smdu_pkg::OP_PUSH, 32'h8000_0000);
        send_op(smdu_pkg::OP_PUSH, 32'hffff_ffff);
        send_op(smdu_pkg::OP_DIV, '0);
        send_op(smdu_pkg::OP_PUSH, '0);
        send_op(smdu_pkg::OP_DIV, '0);            // divide by zero
        send_op(smdu_pkg::OP_DROP, '0);
        send_op(smdu_pkg::OP_PUSH, 32'h7fff_ffff);
        send_op(smdu_pkg::OP_GT, '0);
        send_op(smdu_pkg::OP_PUSH, 32'h7fff_ffff);
        send_op(smdu_pkg::OP_ROT, '0);
        send_op(smdu_pkg::OP_SWAP, '0);
        send_op(smdu_pkg::OP_PUSH, 32'hffff_fffe);
        send_op(smdu_pkg::OP_PICK, '0);           // negative index
        send_op(smdu_pkg::OP_PUSH, 32'd9);
        send_op(smdu_pkg::OP_PICK, '0);           // index past the bottom
        send_op(smdu_pkg::OP_PUSH, 32'd1);
        send_op(smdu_pkg::OP_PICK, '0);
        send_op(smdu_pkg::OP_NEG, '0);
        send_op(smdu_pkg::OP_NOT, '0);
        send_op(smdu_pkg::OP_MUL, '0);
        send_op(smdu_pkg::OP_EQ, '0);
        send_op(OP_SPARE_LO, '0);
    endtask

    // masking in sixteen-bit mode, with and/or left unmasked
    task automatic test_half_mode();
        set_mode(1'b1);
        send_op(smdu_pkg::OP_PUSH, 32'h0001_2345);
        send_op(smdu_pkg::OP_DUP, '0);
        send_op(smdu_pkg::OP_EQ, '0);
        send_op(smdu_pkg::OP_PUSH, 32'hf0f0_0000);
        send_op(smdu_pkg::OP_OR, '0);
        send_op(smdu_pkg::OP_NOT, '0);
        send_op(smdu_pkg::OP_PUSH, 32'h8000_0000);
        send_op(smdu_pkg::OP_AND, '0);
        set_mode(1'b0);
    endtask

    // fill the stack, hit overflow, then empty it
    task automatic test_full_stack();
        while (model_depth < STACK_SIZE)
            send_op(smdu_pkg::OP_PUSH, $urandom);
        send_op(smdu_pkg::OP_PUSH, $urandom);
        send_op(smdu_pkg::OP_DUP, '0);
        send_op(smdu_pkg::OP_ADD, '0);
        while (model_depth > 0)
            send_op($urandom_range(0, 1) ? smdu_pkg::OP_POP : smdu_pkg::OP_DROP, '0);
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct,
                               input logic m, input bit pause_often);
        logic [4:0] op;
        int         k;
        set_mode(m);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (k = 0; k < items; k++)
        begin
            if (pause_often && k % 40 == 39)
                drain_results();
            if (model_depth < 3 && $urandom_range(0, 1))
                op = smdu_pkg::OP_PUSH;
            else if (model_depth > 40 && $urandom_range(0, 1))
                op = smdu_pkg::OP_POP;
            else if ($urandom_range(0, 19) == 0)
                op = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            else
                op = 5'($urandom_range(smdu_pkg::OP_PUSH, smdu_pkg::OP_POP));
            // well-formed pick: push an index that mostly lands inside the stack
            if (op == smdu_pkg::OP_PICK && $urandom_range(0, 2) != 0)
                send_op(smdu_pkg::OP_PUSH, $urandom_range(0, model_depth));
            send_op(op, op == smdu_pkg::OP_PUSH ? pick_value() : $urandom);
        end
    endtask

    // result checker and receiver stall
    always @(posedge clk)
    begin
        result_t exp_r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: status %0d value %h depth %0d",
                                 status, value, depth);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (status !== exp_r.st || value !== exp_r.val || depth !== exp_r.dep)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                                     exp_r.st, exp_r.val, exp_r.dep, status, value, depth);
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = '0;
        push_value     = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        out_ready      = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        model_depth    = 0;
        model_half     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_half_mode();
        test_full_stack();
        test_random(140, 0, 0, 1'b1, 1'b0);
        test_random(140, 48, 0, 1'b0, 1'b0);
        test_random(140, 0, 48, 1'b1, 1'b0);
        test_random(140, 35, 35, 1'b0, 1'b1);

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
